FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the rotation core files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VX_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vaxrot assertion failed");
`define VX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vaxrot assertion failed");
`else
`define VX_ASSERT_IMPL(lbl, ante, cons)
`define VX_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/vaxrot_pkg.sv
// package: widths, register codes, trig sequencer types and helpers
package vaxrot_pkg;

  localparam int COORD_BITS = 32;
  localparam int CB         = COORD_BITS;
  localparam int KW         = 18;
  localparam int ANG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // datapath widths
  localparam int PW    = CB + KW;
  localparam int DOTW  = PW + 2;
  localparam int DW    = DOTW - 16;
  localparam int CRW   = PW + 1;
  localparam int CRRW  = CRW - 16;
  localparam int OMW   = KW + 1;
  localparam int DTW   = DW + OMW;
  localparam int TW    = DTW - 16;
  localparam int TKW   = TW + KW;
  localparam int CSW   = CRRW + KW;
  localparam int ACCW  = TKW + 2;
  localparam int RNDW  = ACCW - 16;
  localparam int NSTG  = 7;

  localparam logic signed [16:0] HALF_Q16 = 17'sd32768;
  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic signed [KW-1:0] ONE_Q16 = 18'sd65536;

  localparam logic [CFG_IDX_W-1:0] REG_AXIS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE  = 3'd3;

  // trig derivation
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam int XW   = 31;
  localparam int X2W  = 32;
  localparam int TQW  = 34;
  localparam int SUMW = 36;
  // every term product shifted down by 30 stays below 2^32
  localparam int QW   = 32;
  localparam int RCW  = 33;
  localparam int QPW  = QW + RCW;

  typedef enum logic [2:0] {
    TRG_IDLE, TRG_XMUL, TRG_X2, TRG_SMUL, TRG_SDIV, TRG_CMUL, TRG_CDIV, TRG_DONE
  } trig_state_t;

  typedef struct packed {
    logic                 busy;
    logic signed [KW-1:0] sin;
    logic signed [KW-1:0] cos;
  } trig_status_t;

  // ceil(2^sh / d) with sh = 32 + ceil(log2 d): exact floor divide for 32-bit dividends
  typedef struct packed {
    logic [RCW-1:0] mult;
    logic [5:0]     sh;
  } recip_t;

  // sine term divisors 6, 20, 42, 72, 110, 156
  function automatic recip_t sin_recip(input logic [2:0] k);
    recip_t r;
    case (k)
      3'd1:    begin r.mult = 33'd5726623062; r.sh = 6'd35; end
      3'd2:    begin r.mult = 33'd6871947674; r.sh = 6'd37; end
      3'd3:    begin r.mult = 33'd6544712071; r.sh = 6'd38; end
      3'd4:    begin r.mult = 33'd7635497416; r.sh = 6'd39; end
      3'd5:    begin r.mult = 33'd4997780127; r.sh = 6'd39; end
      default: begin r.mult = 33'd7048151461; r.sh = 6'd40; end
    endcase
    return r;
  endfunction

  // cosine term divisors 2, 12, 30, 56, 90, 132
  function automatic recip_t cos_recip(input logic [2:0] k);
    recip_t r;
    case (k)
      3'd1:    begin r.mult = 33'd4294967296; r.sh = 6'd33; end
      3'd2:    begin r.mult = 33'd5726623062; r.sh = 6'd36; end
      3'd3:    begin r.mult = 33'd4581298450; r.sh = 6'd37; end
      3'd4:    begin r.mult = 33'd4908534053; r.sh = 6'd38; end
      3'd5:    begin r.mult = 33'd6108397933; r.sh = 6'd39; end
      default: begin r.mult = 33'd8329633544; r.sh = 6'd40; end
    endcase
    return r;
  endfunction

  // clamp to [0, 1.0] in q30, round to q16
  function automatic logic [16:0] trig_round(input logic signed [SUMW-1:0] s);
    logic [30:0] v;
    logic [30:0] t;
    if (s < 0) begin
      v = '0;
    end else if (s > SUMW'(36'sd1073741824)) begin
      v = 31'd1073741824;
    end else begin
      v = s[30:0];
    end
    t = v + 31'd8192;
    return t[30:14];
  endfunction

endpackage

FILE: hw/rtl/vaxrot_in_if.sv
// point request channel
interface vaxrot_in_if import vaxrot_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic signed [CB-1:0] point_x;
  logic signed [CB-1:0] point_y;
  logic signed [CB-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

FILE: hw/rtl/vaxrot_out_if.sv
// rotated point result channel
interface vaxrot_out_if import vaxrot_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic signed [CB-1:0] rotated_x;
  logic signed [CB-1:0] rotated_y;
  logic signed [CB-1:0] rotated_z;
  modport source (output valid, rotated_x, rotated_y, rotated_z, input ready);
  modport sink   (input valid, rotated_x, rotated_y, rotated_z, output ready);
endinterface

FILE: hw/rtl/vaxrot_trig.sv
// sine and cosine sequencer: taylor sums with a shared multiplier and reciprocal divide
`include "assert_macros.svh"
module vaxrot_trig import vaxrot_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ANG_W-1:0] angle,
  output trig_status_t     st
);

  trig_state_t            state_r, state_nxt;
  logic [ANG_W-1:0]       ang_r, ang_nxt;
  logic [XW-1:0]          x_r, x_nxt;
  logic [X2W-1:0]         x2_r, x2_nxt;
  logic [TQW-1:0]         ts_r, ts_nxt, tc_r, tc_nxt;
  logic signed [SUMW-1:0] ssum_r, ssum_nxt, csum_r, csum_nxt;
  logic [2:0]             k_r, k_nxt;
  logic [QW-1:0]          q_r, q_nxt;
  logic signed [KW-1:0]   sin_r, sin_nxt, cos_r, cos_nxt;

  logic [45:0]            xprod;
  logic [61:0]            x2prod;
  logic [65:0]            tprod;
  recip_t                 rc;
  logic [QPW-1:0]         qprod;
  logic [QW-1:0]          quot;
  logic signed [KW-1:0]   s18, c18;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TRG_IDLE;
      sin_r   <= '0;
      cos_r   <= ONE_Q16;
    end else begin
      state_r <= state_nxt;
      sin_r   <= sin_nxt;
      cos_r   <= cos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ang_r  <= ang_nxt;
    x_r    <= x_nxt;
    x2_r   <= x2_nxt;
    ts_r   <= ts_nxt;
    tc_r   <= tc_nxt;
    ssum_r <= ssum_nxt;
    csum_r <= csum_nxt;
    k_r    <= k_nxt;
    q_r    <= q_nxt;
  end

  always_comb begin
    xprod  = 46'(ang_r[13:0]) * 46'(PI_Q30);
    x2prod = 62'(x_r) * 62'(x_r);
    tprod  = 66'((state_r == TRG_SMUL) ? ts_r : tc_r) * 66'(x2_r);
    rc     = (state_r == TRG_SDIV) ? sin_recip(k_r) : cos_recip(k_r);
    // divide by the term constant as a multiply by its reciprocal
    qprod  = QPW'(q_r) * QPW'(rc.mult);
    quot   = QW'(qprod >> rc.sh);
    s18 = KW'(trig_round(ssum_r));
    c18 = KW'(trig_round(csum_r));

    state_nxt = state_r;
    ang_nxt   = ang_r;
    x_nxt     = x_r;
    x2_nxt    = x2_r;
    ts_nxt    = ts_r;
    tc_nxt    = tc_r;
    ssum_nxt  = ssum_r;
    csum_nxt  = csum_r;
    k_nxt     = k_r;
    q_nxt     = q_r;
    sin_nxt   = sin_r;
    cos_nxt   = cos_r;

    unique case (state_r)
      TRG_IDLE: begin
        if (start) begin
          ang_nxt   = angle;
          state_nxt = TRG_XMUL;
        end
      end
      TRG_XMUL: begin
        x_nxt     = xprod[45:15];
        state_nxt = TRG_X2;
      end
      TRG_X2: begin
        x2_nxt    = x2prod[61:30];
        ts_nxt    = TQW'(x_r);
        tc_nxt    = TQW'(34'd1073741824);
        ssum_nxt  = SUMW'(x_r);
        csum_nxt  = SUMW'(36'sd1073741824);
        k_nxt     = 3'd1;
        state_nxt = TRG_SMUL;
      end
      TRG_SMUL, TRG_CMUL: begin
        q_nxt     = tprod[61:30];
        state_nxt = (state_r == TRG_SMUL) ? TRG_SDIV : TRG_CDIV;
      end
      TRG_SDIV: begin
        ts_nxt    = TQW'(quot);
        ssum_nxt  = k_r[0] ? ssum_r - SUMW'(quot) : ssum_r + SUMW'(quot);
        state_nxt = TRG_CMUL;
      end
      TRG_CDIV: begin
        tc_nxt    = TQW'(quot);
        csum_nxt  = k_r[0] ? csum_r - SUMW'(quot) : csum_r + SUMW'(quot);
        k_nxt     = k_r + 1'b1;
        state_nxt = (k_r == 3'd6) ? TRG_DONE : TRG_SMUL;
      end
      TRG_DONE: begin
        case (ang_r[15:14])
          2'd0:    begin sin_nxt = s18;  cos_nxt = c18;  end
          2'd1:    begin sin_nxt = c18;  cos_nxt = -s18; end
          2'd2:    begin sin_nxt = -s18; cos_nxt = -c18; end
          default: begin sin_nxt = -c18; cos_nxt = s18;  end
        endcase
        state_nxt = TRG_IDLE;
      end
      default: state_nxt = TRG_IDLE;
    endcase
  end

  assign st.busy = state_r != TRG_IDLE;
  assign st.sin  = sin_r;
  assign st.cos  = cos_r;

  `VX_ASSERT_IMPL(a_quot_below_dividend, state_r == TRG_SDIV || state_r == TRG_CDIV, quot <= q_r)
  `VX_ASSERT_IMPL(a_term_in_range, state_r == TRG_SMUL || state_r == TRG_CDIV, k_r >= 3'd1 && k_r <= 3'd6)
  `VX_ASSERT_NEXT(a_cos_bounded, state_r == TRG_DONE, cos_r <= ONE_Q16 && cos_r >= -ONE_Q16)

endmodule

FILE: hw/rtl/vector_axis_angle_rotate_core.sv
// rodrigues rotation core: axis/angle config, trig sequencer, 7-stage point pipeline
//  channel  dir  handshake         payload
//  in_ch    in   valid/ready       point_x/y/z, signed q16.16
//  out_ch   out  valid/ready       rotated_x/y/z, signed q16.16, saturated
//  cfg      in   cfg_we only       cfg_idx, cfg_data (axis q2.16, angle)
// one point per cycle while the output is not stalled and the trig sequencer is idle
// an angle write runs the trig sequencer: two setup states, a multiply and a
// reciprocal divide state for each of the 12 taylor terms, one quadrant state;
// no point is taken meanwhile
// a stalled output freezes every stage; synchronous active-low reset
`include "assert_macros.svh"
module vector_axis_angle_rotate_core import vaxrot_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  vaxrot_in_if.sink             in_ch,
  vaxrot_out_if.source          out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic signed [KW-1:0] axis_r [3];
  trig_status_t         trg_st;
  logic                 adv;
  logic                 in_acc;
  logic [NSTG-1:0]      vld_r;

  logic signed [CB-1:0]   v [3];
  logic signed [PW-1:0]   vk_r [3][3];
  logic signed [PW-1:0]   vc1_r [3], vc2_r [3], vc3_r [3], vc4_r [3], vc5_r [3];
  logic signed [DW-1:0]   d_r;
  logic signed [CRRW-1:0] crr_r [3];
  logic signed [DTW-1:0]  dt_r;
  logic signed [CSW-1:0]  cs3_r [3], cs4_r [3], cs5_r [3];
  logic signed [TW-1:0]   t_r;
  logic signed [TKW-1:0]  tk_r [3];
  logic signed [ACCW-1:0] acc_r [3];
  logic signed [CB-1:0]   rot_r [3];

  logic signed [DOTW-1:0] dot_sum;
  logic signed [CRW-1:0]  cr_sum [3];
  logic signed [OMW-1:0]  omc;
  logic signed [DTW-1:0]  dt_rnd;
  logic signed [ACCW-1:0] acc_rnd [3];
  logic signed [RNDW-1:0] rnd [3];

  vaxrot_trig u_trig (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_we && cfg_idx == REG_ANGLE),
    .angle (cfg_data[ANG_W-1:0]),
    .st    (trg_st)
  );

  assign adv          = !vld_r[NSTG-1] || out_ch.ready;
  assign in_ch.ready  = adv && !trg_st.busy;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = vld_r[NSTG-1];
  assign out_ch.rotated_x = rot_r[0];
  assign out_ch.rotated_y = rot_r[1];
  assign out_ch.rotated_z = rot_r[2];

  assign v[0] = in_ch.point_x;
  assign v[1] = in_ch.point_y;
  assign v[2] = in_ch.point_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r[0] <= ONE_Q16;
      axis_r[1] <= '0;
      axis_r[2] <= '0;
      vld_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_AXIS_X: axis_r[0] <= cfg_data;
          REG_AXIS_Y: axis_r[1] <= cfg_data;
          REG_AXIS_Z: axis_r[2] <= cfg_data;
          default: ;
        endcase
      end
      if (adv) begin
        vld_r <= {vld_r[NSTG-2:0], in_acc};
      end
    end
  end

  always_comb begin
    dot_sum = DOTW'(vk_r[0][0]) + DOTW'(vk_r[1][1]) + DOTW'(vk_r[2][2])
            + DOTW'(HALF_Q16);
    cr_sum[0] = CRW'(vk_r[2][1]) - CRW'(vk_r[1][2]) + CRW'(HALF_Q16);
    cr_sum[1] = CRW'(vk_r[0][2]) - CRW'(vk_r[2][0]) + CRW'(HALF_Q16);
    cr_sum[2] = CRW'(vk_r[1][0]) - CRW'(vk_r[0][1]) + CRW'(HALF_Q16);
    omc    = OMW'(ONE_Q16) - OMW'(trg_st.cos);
    dt_rnd = dt_r + DTW'(HALF_Q16);
    for (int i = 0; i < 3; i++) begin
      acc_rnd[i] = acc_r[i] + ACCW'(HALF_Q16);
      rnd[i]     = acc_rnd[i][ACCW-1:16];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        // stage 1: all products against the axis and cosine
        for (int j = 0; j < 3; j++) begin
          vk_r[i][j] <= PW'(v[i]) * PW'(axis_r[j]);
        end
        vc1_r[i] <= PW'(v[i]) * PW'(trg_st.cos);
        // stage 2: rounded cross product
        crr_r[i] <= cr_sum[i][CRW-1:16];
        vc2_r[i] <= vc1_r[i];
        // stage 3: cross times sine
        cs3_r[i] <= CSW'(crr_r[i]) * CSW'(trg_st.sin);
        vc3_r[i] <= vc2_r[i];
        // stage 4
        cs4_r[i] <= cs3_r[i];
        vc4_r[i] <= vc3_r[i];
        // stage 5: axis term
        tk_r[i]  <= TKW'(t_r) * TKW'(axis_r[i]);
        cs5_r[i] <= cs4_r[i];
        vc5_r[i] <= vc4_r[i];
        // stage 6: sum
        acc_r[i] <= ACCW'(vc5_r[i]) + ACCW'(tk_r[i]) + ACCW'(cs5_r[i]);
        // stage 7: round and saturate
        if (rnd[i] > RNDW'(CMAX)) begin
          rot_r[i] <= CMAX;
        end else if (rnd[i] < RNDW'(CMIN)) begin
          rot_r[i] <= CMIN;
        end else begin
          rot_r[i] <= rnd[i][CB-1:0];
        end
      end
      d_r  <= dot_sum[DOTW-1:16];
      dt_r <= DTW'(d_r) * DTW'(omc);
      t_r  <= dt_rnd[DTW-1:16];
    end
  end

  `VX_ASSERT_NEXT(a_accept_enters, in_ch.valid && in_ch.ready, vld_r[0])
  `VX_ASSERT_NEXT(a_stall_freezes, !adv, $stable(vld_r))
  `VX_ASSERT_NEXT(a_angle_starts_trig, cfg_we && cfg_idx == REG_ANGLE, trg_st.busy)

endmodule
